>>> rtl/core/bfds_pkg.sv
package bfds_pkg;

  localparam int CNT_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 48;
  localparam int ADDR_W   = 3;
  localparam int APB_W    = 32;

  localparam logic [CNT_W-1:0] BURST_MAX     = 9'd511;
  localparam logic [CNT_W-1:0] CAPACITY_RST  = 9'd256;
  localparam logic             REG_CAPACITY  = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  function automatic logic [OUT_W-1:0] pack_result(
    input logic              acc,
    input logic [BYTE_W-1:0] rbyte,
    input logic [CNT_W-1:0]  found,
    input logic [CNT_W-1:0]  moved,
    input logic [CNT_W-1:0]  fill,
    input logic [CNT_W-1:0]  free
  );
    return {3'b000, free, fill, moved, found, rbyte, acc};
  endfunction

endpackage

>>> rtl/core/bfds_ram.sv
module bfds_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/byte_fifo_with_delimiter_search_core.sv
// Push and clear: result registered on the accepting edge.
// Pop: the byte store read is registered, then the result in the response state.
// Search: the scan reads one stored byte per cycle through the single read port
// and stops at the first match; an empty fifo is not scanned.
// Synchronous active-high reset clears pointers, counts and the output valid;
// capacity returns to 256. Stored bytes are not cleared.
module byte_fifo_with_delimiter_search_core #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: operation[1:0], data_byte[9:2]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfds_pkg::IN_W-1:0]     s_tdata,
  input  logic                          s_tlast,
  // m_tdata: accepted[0], read_byte[8:1], found_position[17:9],
  //          burst_moved[26:18], fill_level[35:27], free_space[44:36]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfds_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfds_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfds_pkg::APB_W-1:0]    pwdata,
  output logic [bfds_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);

  import bfds_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                             input logic [EW-1:0] cap);
    logic [EW-1:0] nx;
    nx = EW'(p) + EW'(1);
    return (nx >= cap) ? '0 : nx[PW-1:0];
  endfunction

  state_t            state;
  logic [PW-1:0]     rd_ptr, wr_ptr, scan_addr;
  logic [CNT_W-1:0]  count, burst, capacity, scan_k;
  logic [BYTE_W-1:0] scan_key;

  logic              pend_acc, pend_pop;
  logic [CNT_W-1:0]  pend_found, pend_moved, pend_fill, pend_free;

  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  op_t               op;
  logic [BYTE_W-1:0] din;
  logic              accept, out_free, cfg_wr;
  logic [EW-1:0]     cap_ext, cap_use_w;
  logic [CNT_W-1:0]  cap_use;

  logic              acc;
  logic [PW-1:0]     rd_ptr_next, wr_ptr_next;
  logic [CNT_W-1:0]  count_next, burst_next, moved, free_next, burst_inc;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              match, last_entry, scan_issue;
  logic [CNT_W-1:0]  scan_pos;

  assign op       = op_t'(s_tdata[1:0]);
  assign din      = s_tdata[9:2];
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_W'(capacity) : '0;

  // capacity above the storage depth acts as the depth
  assign cap_ext   = EW'(capacity);
  assign cap_use_w = (cap_ext > DEPTH_E) ? DEPTH_E : cap_ext;
  assign cap_use   = cap_use_w[CNT_W-1:0];

  always_comb begin
    acc         = 1'b0;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    burst_next  = burst;
    moved       = '0;
    case (op)
      OP_PUSH: begin
        if (count < cap_use) begin
          acc         = 1'b1;
          wr_ptr_next = advance(wr_ptr, cap_use_w);
          count_next  = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count != '0) begin
          acc         = 1'b1;
          rd_ptr_next = advance(rd_ptr, cap_use_w);
          count_next  = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        rd_ptr_next = '0;
        wr_ptr_next = '0;
        count_next  = '0;
      end
      default: begin
      end
    endcase
    burst_inc = (acc && burst != BURST_MAX) ? burst + CNT_W'(1) : burst;
    if (op == OP_PUSH || op == OP_POP) begin
      if (s_tlast) begin
        moved      = burst_inc;
        burst_next = '0;
      end else begin
        burst_next = burst_inc;
      end
    end
    free_next = (cap_use > count_next) ? cap_use - count_next : '0;
  end

  // scan: ram_rdata holds entry scan_k of the stored bytes
  assign scan_pos   = scan_k + CNT_W'(1);
  assign match      = (ram_rdata == scan_key);
  assign last_entry = (scan_pos == count);
  assign scan_issue = (state == ST_SCAN) && !match && !last_entry;

  assign ram_we    = accept && (op == OP_PUSH) && acc;
  assign ram_re    = (accept && ((op == OP_POP && acc) || (op == OP_SEARCH && count != '0)))
                     || scan_issue;
  assign ram_raddr = (state == ST_IDLE) ? rd_ptr : scan_addr;

  bfds_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (din),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      burst     <= '0;
      capacity  <= CAPACITY_RST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_ptr <= rd_ptr_next;
            wr_ptr <= wr_ptr_next;
            count  <= count_next;
            burst  <= burst_next;
            if (op == OP_POP || (op == OP_SEARCH && count != '0)) begin
              pend_acc   <= acc;
              pend_pop   <= (op == OP_POP) && acc;
              pend_found <= '0;
              pend_moved <= moved;
              pend_fill  <= count_next;
              pend_free  <= free_next;
              scan_addr  <= advance(rd_ptr, cap_use_w);
              scan_k     <= '0;
              scan_key   <= din;
              state      <= (op == OP_POP) ? ST_RESP : ST_SCAN;
            end else begin
              out_valid <= 1'b1;
              out_data  <= pack_result(acc, '0, '0, moved, count_next, free_next);
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            pend_found <= scan_pos;
            state      <= ST_RESP;
          end else if (last_entry) begin
            state <= ST_RESP;
          end else begin
            scan_addr <= advance(scan_addr, cap_use_w);
            scan_k    <= scan_pos;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= pack_result(pend_acc, pend_pop ? ram_rdata : '0, pend_found,
                                     pend_moved, pend_fill, pend_free);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // register write restarts the fifo, as at initialization
      if (cfg_wr) begin
        capacity <= pwdata[CNT_W-1:0];
        rd_ptr   <= '0;
        wr_ptr   <= '0;
        count    <= '0;
        burst    <= '0;
      end
    end
  end

endmodule

>>> rtl/core/bfds_checker.sv
module bfds_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [bfds_pkg::OUT_W-1:0]  m_tdata
);

  import bfds_pkg::*;

  logic             o_acc;
  logic [7:0]       o_rbyte;
  logic [CNT_W-1:0] o_found, o_moved, o_fill;

  assign o_acc   = m_tdata[0];
  assign o_rbyte = m_tdata[8:1];
  assign o_found = m_tdata[17:9];
  assign o_moved = m_tdata[26:18];
  assign o_fill  = m_tdata[35:27];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a nonzero byte only comes out of a delivered pop
  a_rbyte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_rbyte != '0 |-> o_acc && o_found == '0)
    else $error("read byte without a pop");

  // a search hit lies inside the stored bytes and is no transfer
  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_found != '0 |-> o_found <= o_fill && !o_acc && o_moved == '0)
    else $error("search position out of range");

  // an input transfer only while the output register can take a result
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("item accepted while a result is blocked");

endmodule

bind byte_fifo_with_delimiter_search_core bfds_checker u_bfds_checker (.*);

>>> dv/byte_fifo_with_delimiter_search_core_tb.sv
`timescale 1ns / 100ps

module byte_fifo_with_delimiter_search_core_tb;
  import bfds_pkg::*;

  localparam int DEPTH = 256;
  localparam int LIMIT = 1_000_000;
  localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * REG_CAPACITY);

  typedef struct packed {
    logic              acc;
    logic [BYTE_W-1:0] rbyte;
    logic [CNT_W-1:0]  found;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  free;
  } outcome_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              typed;
    outcome_t          want;
  } step_t;

  localparam outcome_t NONE = '0;

  // typed rows: after reset, capacity 256
  localparam step_t DIRECTED [20] = '{
    '{OP_POP,    8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 9'd0, 9'd256}},
    '{OP_SEARCH, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 9'd0, 9'd0, 9'd0, 9'd256}},
    '{OP_PUSH,   8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 9'd0, 9'd0, 9'd1, 9'd255}},
    '{OP_PUSH,   8'hFF, 1'b1, 1'b1, '{1'b1, 8'h00, 9'd0, 9'd2, 9'd2, 9'd254}},
    '{OP_SEARCH, 8'hFF, 1'b0, 1'b1, '{1'b0, 8'h00, 9'd2, 9'd0, 9'd2, 9'd254}},
    '{OP_SEARCH, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 9'd1, 9'd0, 9'd2, 9'd254}},
    '{OP_SEARCH, 8'h55, 1'b0, 1'b0, NONE},
    '{OP_PUSH,   8'hAA, 1'b0, 1'b0, NONE},
    '{OP_PUSH,   8'h55, 1'b1, 1'b0, NONE},
    // tlast on a search is ignored
    '{OP_SEARCH, 8'h55, 1'b1, 1'b0, NONE},
    '{OP_POP,    8'hC3, 1'b0, 1'b0, NONE},
    // clear keeps the burst count
    '{OP_CLEAR,  8'h3C, 1'b1, 1'b0, NONE},
    '{OP_POP,    8'h00, 1'b1, 1'b0, NONE},
    '{OP_PUSH,   8'h5A, 1'b0, 1'b0, NONE},
    '{OP_PUSH,   8'hA5, 1'b1, 1'b0, NONE},
    '{OP_POP,    8'h00, 1'b0, 1'b0, NONE},
    '{OP_POP,    8'h00, 1'b0, 1'b0, NONE},
    '{OP_POP,    8'h00, 1'b1, 1'b0, NONE},
    '{OP_SEARCH, 8'hA5, 1'b0, 1'b0, NONE},
    '{OP_CLEAR,  8'hFF, 1'b0, 1'b0, NONE}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  // typed expectation travels alongside the transfer
  logic              row_typed = 1'b0;
  outcome_t          row_want = '0;

  logic              quiet = 1'b0;

  // shadow fifo
  logic [BYTE_W-1:0] fifo_mem [DEPTH];
  int unsigned       rd_ptr = 0;
  int unsigned       wr_ptr = 0;
  int unsigned       held = 0;
  int unsigned       burst_cnt = 0;
  int unsigned       cap_reg = 256;

  outcome_t          pending_q [$];
  int                errors = 0;
  int                n_in = 0;
  int                n_out = 0;
  int                n_hits = 0;
  int                n_cfg = 0;
  int                cycles = 0;

  byte_fifo_with_delimiter_search_core #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned cap_eff();
    return (cap_reg > DEPTH) ? DEPTH : cap_reg;
  endfunction

  function automatic int unsigned wrap_next(input int unsigned p, input int unsigned c);
    return (p + 1 >= c) ? 0 : p + 1;
  endfunction

  function automatic outcome_t fifo_predict(input op_t op, input logic [BYTE_W-1:0] b,
                                            input logic last);
    outcome_t    r;
    int unsigned c;
    int unsigned p;
    c = cap_eff();
    r = '0;
    case (op)
      OP_PUSH: begin
        if (held < c) begin
          fifo_mem[wr_ptr] = b;
          wr_ptr = wrap_next(wr_ptr, c);
          held++;
          r.acc = 1'b1;
        end
      end
      OP_POP: begin
        if (held > 0) begin
          r.rbyte = fifo_mem[rd_ptr];
          rd_ptr = wrap_next(rd_ptr, c);
          held--;
          r.acc = 1'b1;
        end
      end
      OP_SEARCH: begin
        p = rd_ptr;
        for (int k = 0; k < held; k++) begin
          if (r.found == 0 && fifo_mem[p] == b) r.found = CNT_W'(k + 1);
          p = wrap_next(p, c);
        end
      end
      default: begin
        rd_ptr = 0;
        wr_ptr = 0;
        held = 0;
      end
    endcase
    if (op == OP_PUSH || op == OP_POP) begin
      if (r.acc && burst_cnt < BURST_MAX) burst_cnt++;
      if (last) begin
        r.moved = CNT_W'(burst_cnt);
        burst_cnt = 0;
      end
    end
    r.fill = CNT_W'(held);
    r.free = CNT_W'((c > held) ? c - held : 0);
    return r;
  endfunction

  // transfer tracking, prediction and checking
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    outcome_t pred;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        cap_reg = pwdata[CNT_W-1:0];
        rd_ptr = 0;
        wr_ptr = 0;
        held = 0;
        burst_cnt = 0;
      end
      if (s_tvalid && s_tready) begin
        pred = fifo_predict(op_t'(s_tdata[1:0]), s_tdata[9:2], s_tlast);
        pending_q.push_back(row_typed ? row_want : pred);
        n_in++;
      end
      if (m_tvalid && m_tready) begin
        got.acc   = m_tdata[0];
        got.rbyte = m_tdata[8:1];
        got.found = m_tdata[17:9];
        got.moved = m_tdata[26:18];
        got.fill  = m_tdata[35:27];
        got.free  = m_tdata[44:36];
        n_out++;
        if (got.found != 0) n_hits++;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: exp acc=%0d rd=%h pos=%0d mv=%0d fill=%0d free=%0d",
                       n_out, want.acc, want.rbyte, want.found, want.moved, want.fill,
                       want.free);
            if (errors <= 10)
              $display("                     got acc=%0d rd=%h pos=%0d mv=%0d fill=%0d free=%0d",
                       got.acc, got.rbyte, got.found, got.moved, got.fill, got.free);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("byte_fifo_with_delimiter_search_core_tb: errors");
      $finish;
    end
  end

  task automatic send(input op_t op, input logic [BYTE_W-1:0] b, input logic last,
                      input logic typed, input outcome_t want);
    if (!quiet && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= IN_W'({b, op});
    s_tlast   <= last;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_plain(input op_t op, input logic [BYTE_W-1:0] b, input logic last);
    send(op, b, last, 1'b0, NONE);
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int unsigned val);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    n_cfg++;
    // back-to-back read of the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CNT_W-1:0] != CNT_W'(val)) begin
      errors++;
      if (errors <= 10) $display("capacity readback %0d, wrote %0d", prdata[CNT_W-1:0], val);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // small alphabet so that searches hit often
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h0A;
      2: return 8'h0D;
      3: return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic run_stream(input int n, input int max_len, input int push_pct);
    int   sent;
    int   len;
    int   r;
    op_t  op;
    op_t  op_i;
    logic broken;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_plain(OP_SEARCH, pick_byte(), 1'($urandom_range(1)));
        sent++;
      end else if (r < 11) begin
        send_plain(OP_CLEAR, BYTE_W'($urandom), 1'($urandom_range(1)));
        sent++;
      end else begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        len = $urandom_range(1, max_len);
        broken = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
          op_i = ($urandom_range(19) == 0) ? op_t'($urandom_range(3)) : op;
          send_plain(op_i, pick_byte(), (i == len - 1) && !broken);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed,
           DIRECTED[i].want);

    // full depth: overfill, full scans, then drain past empty; burst count saturates
    set_capacity(256);
    for (int i = 0; i < 258; i++) begin
      b = pick_byte();
      if (b == 8'h7E) b = 8'h7F;
      send_plain(OP_PUSH, b, 1'b0);
    end
    send_plain(OP_SEARCH, 8'h7E, 1'b0);
    send_plain(OP_SEARCH, pick_byte(), 1'b0);
    send_plain(OP_SEARCH, pick_byte(), 1'b1);
    for (int i = 0; i < 258; i++) send_plain(OP_POP, 8'h00, i == 257);

    set_capacity(1);
    run_stream(12, 3, 55);
    drain();
    run_stream(12, 3, 55);

    set_capacity(2);
    run_stream(12, 5, 55);

    set_capacity(0);
    run_stream(8, 4, 60);

    set_capacity(511);
    run_stream(14, 8, 65);

    set_capacity(300);
    quiet = 1'b1;
    run_stream(12, 8, 60);
    quiet = 1'b0;

    set_capacity($urandom_range(3, 40));
    run_stream(12, 6, 55);

    drain();
    repeat (260) @(posedge clk);
    if (pending_q.size() != 0) begin
      errors += pending_q.size();
      $display("%0d results never arrived", pending_q.size());
    end

    $display("%0d transfers in, %0d results out, %0d delimiter hits, %0d capacity writes",
             n_in, n_out, n_hits, n_cfg);
    $display("capacities 256, 1, 2, 0, 511, 300 and one random; %0d cycles", cycles);
    if (errors == 0) begin
      $display("byte_fifo_with_delimiter_search_core_tb: clean");
    end else begin
      $display("byte_fifo_with_delimiter_search_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bfds_pkg.sv
rtl/core/bfds_ram.sv
rtl/core/byte_fifo_with_delimiter_search_core.sv
rtl/core/bfds_checker.sv
dv/byte_fifo_with_delimiter_search_core_tb.sv
